>>> hdl/rbank_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the relay bank with auto-off timers.
// No dependencies.
package rbank_pkg;

	localparam int DEF_CHANNELS = 16;
	localparam int SEC_W        = 24;
	localparam int OUT_W        = 16;
	localparam int CH_W         = 4;
	localparam int CNT_W        = 5;
	localparam int CFG_W        = 16;
	localparam int REG_W        = 1;

	localparam logic [REG_W-1:0] REG_CHANNEL_COUNT = 1'd0;
	localparam logic [REG_W-1:0] REG_ACTIVE_LOW    = 1'd1;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_ON     = 3'd1,
		CMD_OFF    = 3'd2,
		CMD_TOGGLE = 3'd3,
		CMD_SET    = 3'd4,
		CMD_QUERY  = 3'd5
	} cmd_t;

	typedef struct packed {
		logic [SEC_W-1:0] dur;
		logic [SEC_W-1:0] rem;
	} timer_entry_t;

endpackage

>>> hdl/rbank_timer_mem.sv
`timescale 1ns / 1ps
// Per-channel timer store: auto-off duration and countdown, one write and
// one registered read per cycle; entries never written read as zero.
// Depends on rbank_pkg.
module rbank_timer_mem import rbank_pkg::*; #(
	parameter int DEPTH = DEF_CHANNELS,
	parameter int AW    = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         we,
	input  logic [AW-1:0] waddr,
	input  timer_entry_t wdata,
	input  logic         re,
	input  logic [AW-1:0] raddr,
	output timer_entry_t rdata
);

	timer_entry_t mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	timer_entry_t rdata_q;
	logic rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

>>> hdl/relay_bank_with_auto_off.sv
`timescale 1ns / 1ps
// Relay bank with per-channel auto-off countdowns.
// Depends on rbank_pkg and rbank_timer_mem.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one command item: cmd, channel,
//   seconds. Output channel (out_valid/out_ready) returns one result item
//   per command: status, channel_on, relay_states, pin_levels, written_mask.
//   Config port: cfg_en/cfg_idx/cfg_data, index 0 channel_count, index 1
//   pin polarity mask; write only while no item is in flight.
//   Operation: a small sequencer drives the timer store read and write
//   ports and one decrementer. A channel command passes read, execute and
//   finish steps before its result is registered; a tick walks the channels
//   with a read and an execute step each, then finishes. in_ready is high
//   only when the sequencer is idle, so one item is worked on at a time.
//   Codes 6 and 7 go straight to the finish step.
//   The result register decouples the output: the next item is accepted
//   while a result waits; if the receiver stalls, the following item holds
//   in its finish step until the register frees up.
//   Reset (arst_n low) clears relays, timers (via valid bits), config and
//   both handshakes; no clearing pass is needed.
module relay_bank_with_auto_off import rbank_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_en,
	input  logic [REG_W-1:0]  cfg_idx,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        cmd,
	input  logic [CH_W-1:0]   channel,
	input  logic [SEC_W-1:0]  seconds,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              status,
	output logic              channel_on,
	output logic [OUT_W-1:0]  relay_states,
	output logic [OUT_W-1:0]  pin_levels,
	output logic [OUT_W-1:0]  written_mask
);

	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PW = (CHANNELS > OUT_W) ? CHANNELS : OUT_W;
	localparam logic [5:0] CH_LIM = 6'(CHANNELS);
	localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CRD,
		S_CEX,
		S_TRD,
		S_TEX,
		S_FIN
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic [CH_W-1:0] ch_q;
	logic [SEC_W-1:0] secs_q;
	logic [IW-1:0] idx_q;
	logic [CNT_W-1:0] chan_cnt_q;
	logic [OUT_W-1:0] low_mask_q;
	logic [CHANNELS-1:0] relay_q;
	logic [CHANNELS-1:0] wr_q;
	logic status_q;
	logic chon_q;

	logic out_valid_q;
	logic status_o_q;
	logic chon_o_q;
	logic [OUT_W-1:0] states_o_q;
	logic [OUT_W-1:0] pins_o_q;
	logic [OUT_W-1:0] wmask_o_q;

	logic [5:0] act;
	logic [IW-1:0] ch_idx;
	logic ch_err;
	logic relay_cur;

	logic mem_we;
	logic [IW-1:0] mem_waddr;
	timer_entry_t mem_wdata;
	logic mem_re;
	logic [IW-1:0] mem_raddr;
	timer_entry_t entry;

	logic [SEC_W-1:0] dec;
	logic rel_we;
	logic rel_val;
	logic [PW-1:0] relay_pad;
	logic [PW-1:0] wr_pad;

	rbank_timer_mem #(
		.DEPTH(CHANNELS),
		.AW   (IW)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (entry)
	);

	assign act       = ({1'b0, chan_cnt_q} > CH_LIM) ? CH_LIM : {1'b0, chan_cnt_q};
	assign ch_idx    = IW'(ch_q);
	assign ch_err    = ({2'b00, ch_q} >= act);
	assign relay_cur = relay_q[ch_idx];
	assign dec       = entry.rem - SEC_W'(1);

	assign mem_re    = (state_q == S_CRD) || (state_q == S_TRD);
	assign mem_raddr = (state_q == S_TRD) ? idx_q : ch_idx;

	// shared execute step for ticks and channel commands: one timer entry at a time
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ch_idx;
		mem_wdata = entry;
		rel_we    = 1'b0;
		rel_val   = 1'b0;
		if (state_q == S_TEX) begin
			mem_waddr     = idx_q;
			mem_wdata.rem = dec;
			mem_we        = (entry.rem != '0);
			rel_we        = mem_we && (dec == '0) && ({1'b0, 5'(idx_q)} < act);
			rel_val       = 1'b0;
		end else if (state_q == S_CEX && !ch_err) begin
			case (cmd_q)
				CMD_ON, CMD_TOGGLE: begin
					rel_we  = 1'b1;
					rel_val = (cmd_q == CMD_ON) || !relay_cur;
					if (!rel_val) begin
						mem_we        = 1'b1;
						mem_wdata.rem = '0;
					end else if (entry.dur != '0) begin
						mem_we        = 1'b1;
						mem_wdata.rem = entry.dur;
					end
				end
				CMD_OFF: begin
					rel_we        = 1'b1;
					rel_val       = 1'b0;
					mem_we        = 1'b1;
					mem_wdata.rem = '0;
				end
				CMD_SET: begin
					mem_we        = 1'b1;
					mem_wdata.dur = secs_q;
					mem_wdata.rem = (secs_q != '0 && relay_cur) ? secs_q : '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign relay_pad = PW'(relay_q);
	assign wr_pad    = PW'(wr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= CMD_TICK;
			ch_q        <= '0;
			secs_q      <= '0;
			idx_q       <= '0;
			chan_cnt_q  <= '0;
			low_mask_q  <= '0;
			relay_q     <= '0;
			wr_q        <= '0;
			status_q    <= 1'b0;
			chon_q      <= 1'b0;
			out_valid_q <= 1'b0;
			status_o_q  <= 1'b0;
			chon_o_q    <= 1'b0;
			states_o_q  <= '0;
			pins_o_q    <= '0;
			wmask_o_q   <= '0;
		end else begin
			if (cfg_en) begin
				case (cfg_idx)
					REG_CHANNEL_COUNT: chan_cnt_q <= cfg_data[CNT_W-1:0];
					REG_ACTIVE_LOW:    low_mask_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q    <= cmd_t'(cmd);
						ch_q     <= channel;
						secs_q   <= seconds;
						idx_q    <= '0;
						wr_q     <= '0;
						status_q <= 1'b0;
						chon_q   <= 1'b0;
						case (cmd)
							CMD_TICK:                          state_q <= S_TRD;
							CMD_ON, CMD_OFF, CMD_TOGGLE,
							CMD_SET, CMD_QUERY:                state_q <= S_CRD;
							default:                           state_q <= S_FIN;
						endcase
					end
				end
				S_CRD: begin
					state_q <= S_CEX;
				end
				S_CEX: begin
					if (ch_err) begin
						status_q <= 1'b1;
					end else begin
						if (rel_we) begin
							relay_q[ch_idx] <= rel_val;
							wr_q[ch_idx]    <= 1'b1;
							chon_q          <= rel_val;
						end else begin
							chon_q <= relay_cur;
						end
					end
					state_q <= S_FIN;
				end
				S_TRD: begin
					state_q <= S_TEX;
				end
				S_TEX: begin
					if (rel_we) begin
						relay_q[idx_q] <= 1'b0;
						wr_q[idx_q]    <= 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_TRD;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_o_q  <= status_q;
						chon_o_q    <= chon_q;
						states_o_q  <= relay_pad[OUT_W-1:0];
						pins_o_q    <= relay_pad[OUT_W-1:0] ^ low_mask_q;
						wmask_o_q   <= wr_pad[OUT_W-1:0];
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_o_q;
	assign channel_on   = chon_o_q;
	assign relay_states = states_o_q;
	assign pin_levels   = pins_o_q;
	assign written_mask = wmask_o_q;

endmodule

>>> hdl/rbank_chk.sv
`timescale 1ns / 1ps
// Port-level checks for the relay bank, bound to the top level.
// Depends on rbank_pkg.
module rbank_chk import rbank_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             status,
	input logic             channel_on,
	input logic [OUT_W-1:0] relay_states,
	input logic [OUT_W-1:0] written_mask
);

	// one item at a time: accepting drops ready
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an accepted item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(relay_states) &&
		$stable(written_mask) && $stable(status))
		else $error("stalled result changed");

	// out-of-range channel must leave everything untouched
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> written_mask == '0 && !channel_on)
		else $error("error result with side effects");

	// a result with channel_on set has at most one written channel
	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && channel_on |-> $countones(written_mask) <= 1)
		else $error("channel command wrote several channels");

endmodule

bind relay_bank_with_auto_off rbank_chk u_rbank_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.channel_on  (channel_on),
	.relay_states(relay_states),
	.written_mask(written_mask)
);
